@@ hdl/fabt_pkg.sv @@
// ----------------------------------------------------------------------------
// fabt_pkg
// Shared types and constants for the failed-auth ban table.
// ----------------------------------------------------------------------------
package fabt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int ADDR_W   = 32;
  localparam int TIME_W   = 32;
  localparam int FAIL_W   = 8;
  localparam int ENTRY_W  = 5;
  localparam int REQ_W    = 2;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [FAIL_W-1:0]  FAIL_RST = 8'd5;
  localparam logic [TIME_W-1:0]  BAN_RST  = 32'd60000;
  localparam logic [FAIL_W-1:0]  FAIL_SAT = 8'hFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FAIL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BAN_TIME = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_CHECK   = 2'd0,
    REQ_SUCCESS = 2'd1,
    REQ_FAIL    = 2'd2,
    REQ_TICK    = 2'd3
  } req_type_t;

  // per-entry compare result
  typedef struct packed {
    logic expired;
    logic match;
  } cmp_res_t;

endpackage

@@ hdl/fabt_entry_cmp.sv @@
// ----------------------------------------------------------------------------
// fabt_entry_cmp
// Shared entry compare unit: age check against the ban time and address match.
// ----------------------------------------------------------------------------
module fabt_entry_cmp (
  input  logic [fabt_pkg::ADDR_W-1:0] entry_addr,
  input  logic [fabt_pkg::TIME_W-1:0] entry_time,
  input  logic [fabt_pkg::ADDR_W-1:0] req_addr,
  input  logic [fabt_pkg::TIME_W-1:0] time_now,
  input  logic [fabt_pkg::TIME_W-1:0] ban_ticks,
  output fabt_pkg::cmp_res_t          res
);

  logic [fabt_pkg::TIME_W-1:0] age;

  // age wraps modulo 2^32
  assign age         = time_now - entry_time;
  assign res.expired = (age >= ban_ticks);
  assign res.match   = (entry_addr == req_addr);

endmodule

@@ hdl/failed_auth_ban_table_top.sv @@
// ----------------------------------------------------------------------------
// failed_auth_ban_table_top
// Table of peer addresses with failed logins, aged out by a tick counter.
// ----------------------------------------------------------------------------
// Input beats carry a request kind on in_tuser and a peer address on in_tdata.
// Check, success and failure requests walk the table one entry per cycle
// through a single compare unit (age vs. ban time, address equality), dropping
// aged entries and locating the address and the lowest free slot. S_ACT then
// applies the update, and S_RESP loads the output register.
// Check/success/failure pass through S_SWEEP, S_ACT and S_RESP in that order;
// the sweep length is set by the table depth.
// Tick: advances the time counter and goes from S_IDLE straight to S_RESP.
// Every request returns exactly one result beat. in_tready is high only while
// the sequencer is idle. A stalled result holds in the output register; the
// sequencer waits in its response state until that register frees.
// Reset clears valid marks, the time counter and restores register defaults;
// the table contents need no clearing pass.
// Config writes (cfg_we) are expected only while no request is in flight.
// ----------------------------------------------------------------------------
module failed_auth_ban_table_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fabt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fabt_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // [31:0] ip_address
  input  logic [1:0]                     in_tuser,   // [1:0] req_type
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata   // [0] banned, [1] table_full,
                                                     // [6:2] entries_in_use
);

  localparam int N = fabt_pkg::TABLE_ENTRIES;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SWEEP = 4'b0010,
    S_ACT   = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [fabt_pkg::FAIL_W-1:0] max_fail_r;
  logic [fabt_pkg::TIME_W-1:0] ban_ticks_r;
  logic [fabt_pkg::TIME_W-1:0] time_now_r, time_now_nxt;

  logic [N-1:0]                valid_r, valid_nxt;
  logic [fabt_pkg::ADDR_W-1:0] addr_mem_r [N];
  logic [fabt_pkg::TIME_W-1:0] time_mem_r [N];
  logic [fabt_pkg::FAIL_W-1:0] cnt_mem_r  [N];

  logic [fabt_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [fabt_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  fabt_pkg::req_type_t         req_r, req_nxt;
  logic [fabt_pkg::ADDR_W-1:0] req_addr_r, req_addr_nxt;

  logic                        hit_r, hit_nxt;
  logic [fabt_pkg::IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic [fabt_pkg::FAIL_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic                        free_r, free_nxt;
  logic [fabt_pkg::IDX_W-1:0]  free_idx_r, free_idx_nxt;

  logic                        res_banned_r, res_banned_nxt;
  logic                        res_full_r, res_full_nxt;
  logic [fabt_pkg::ENTRY_W-1:0] res_entries_r, res_entries_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_data_r, out_data_nxt;

  // table write port
  logic                        wr_entry;
  logic                        wr_cnt;
  logic [fabt_pkg::IDX_W-1:0]  wr_idx;
  logic [fabt_pkg::FAIL_W-1:0] wr_cnt_val;

  logic                        in_acc;
  logic                        tick_acc;
  logic                        live;
  fabt_pkg::cmp_res_t          cmp;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign tick_acc   = in_acc && (fabt_pkg::req_type_t'(in_tuser) == fabt_pkg::REQ_TICK);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  fabt_entry_cmp u_cmp (
    .entry_addr (addr_mem_r[idx_r]),
    .entry_time (time_mem_r[idx_r]),
    .req_addr   (req_addr_r),
    .time_now   (time_now_r),
    .ban_ticks  (ban_ticks_r),
    .res        (cmp)
  );

  // entry still present after aging
  assign live = valid_r[idx_r] && !cmp.expired;

  always_comb begin
    state_nxt       = state_r;
    time_now_nxt    = time_now_r;
    valid_nxt       = valid_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    req_nxt         = req_r;
    req_addr_nxt    = req_addr_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    hit_cnt_nxt     = hit_cnt_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    res_banned_nxt  = res_banned_r;
    res_full_nxt    = res_full_r;
    res_entries_nxt = res_entries_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    wr_entry        = 1'b0;
    wr_cnt          = 1'b0;
    wr_idx          = free_idx_r;
    wr_cnt_val      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (tick_acc) begin
            time_now_nxt    = time_now_r + 1'b1;
            res_banned_nxt  = 1'b0;
            res_full_nxt    = 1'b0;
            res_entries_nxt = fabt_pkg::ENTRY_W'(count_r);
            state_nxt       = S_RESP;
          end else begin
            req_nxt      = fabt_pkg::req_type_t'(in_tuser);
            req_addr_nxt = in_tdata;
            idx_nxt      = '0;
            count_nxt    = '0;
            hit_nxt      = 1'b0;
            free_nxt     = 1'b0;
            state_nxt    = S_SWEEP;
          end
        end
      end

      S_SWEEP: begin
        valid_nxt[idx_r] = live;
        if (live) begin
          count_nxt = count_r + 1'b1;
          if (cmp.match && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = idx_r;
            hit_cnt_nxt = cnt_mem_r[idx_r];
          end
        end else if (!free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = idx_r;
        end
        if (idx_r == fabt_pkg::IDX_W'(N - 1)) begin
          state_nxt = S_ACT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_ACT: begin
        res_banned_nxt = 1'b0;
        res_full_nxt   = 1'b0;
        case (req_r)
          fabt_pkg::REQ_CHECK: begin
            res_banned_nxt = hit_r && (hit_cnt_r >= max_fail_r);
          end
          fabt_pkg::REQ_SUCCESS: begin
            if (hit_r) begin
              valid_nxt[hit_idx_r] = 1'b0;
              count_nxt            = count_r - 1'b1;
            end
          end
          fabt_pkg::REQ_FAIL: begin
            if (hit_r) begin
              wr_cnt     = (hit_cnt_r != fabt_pkg::FAIL_SAT);
              wr_idx     = hit_idx_r;
              wr_cnt_val = hit_cnt_r + 1'b1;
            end else if (free_r) begin
              wr_entry              = 1'b1;
              wr_cnt                = 1'b1;
              wr_idx                = free_idx_r;
              valid_nxt[free_idx_r] = 1'b1;
              count_nxt             = count_r + 1'b1;
            end else begin
              res_full_nxt = 1'b1;
            end
          end
          default: ;
        endcase
        res_entries_nxt = fabt_pkg::ENTRY_W'(count_nxt);
        state_nxt       = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, res_entries_r, res_full_r, res_banned_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_fail_r  <= fabt_pkg::FAIL_RST;
      ban_ticks_r <= fabt_pkg::BAN_RST;
      time_now_r  <= '0;
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_now_r  <= time_now_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          fabt_pkg::REG_MAX_FAIL: max_fail_r  <= cfg_wdata[fabt_pkg::FAIL_W-1:0];
          fabt_pkg::REG_BAN_TIME: ban_ticks_r <= cfg_wdata[fabt_pkg::TIME_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers and table storage, no reset
  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    req_r         <= req_nxt;
    req_addr_r    <= req_addr_nxt;
    hit_r         <= hit_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_cnt_r     <= hit_cnt_nxt;
    free_r        <= free_nxt;
    free_idx_r    <= free_idx_nxt;
    res_banned_r  <= res_banned_nxt;
    res_full_r    <= res_full_nxt;
    res_entries_r <= res_entries_nxt;
    out_data_r    <= out_data_nxt;
    if (wr_entry) begin
      addr_mem_r[wr_idx] <= req_addr_r;
      time_mem_r[wr_idx] <= time_now_r;
    end
    if (wr_cnt) begin
      cnt_mem_r[wr_idx] <= wr_cnt_val;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // running count matches the valid marks whenever the sequencer rests
  a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (count_r == fabt_pkg::CNT_W'($countones(valid_r))))
    else $error("entry count out of step with valid marks");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fabt_pkg::CNT_W'(N))
    else $error("entry count above table size");

  // a full flag only when every entry is in use
  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && res_full_r) |->
      (res_entries_r == fabt_pkg::ENTRY_W'(N)))
    else $error("table_full reported with free entries");

  // time moves only on an accepted tick
  a_time_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(time_now_r) |-> $past(tick_acc))
    else $error("time counter moved without a tick");

  // a sweep always finishes on the last entry
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && state_nxt == S_ACT) |->
      (idx_r == fabt_pkg::IDX_W'(N - 1)))
    else $error("sweep left early");

endmodule

@@ bench/ban_table_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ban_table_checker
// Watches the request, result and register ports of the ban table, keeps
// its own copy of the table, and compares every result beat with the verdict
// predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module ban_table_checker
  import fabt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [31:0]          in_tdata,    // [31:0] ip_address
  input  logic [1:0]           in_tuser,    // [1:0] req_type
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [7:0]           out_tdata,   // [0] banned, [1] table_full,
                                            // [6:2] entries_in_use
  output int                   mismatches,
  output int                   awaiting
);

  typedef struct packed {
    logic              banned;
    logic              full;
    logic [ENTRY_W-1:0] in_use;
  } verdict_t;

  // shadow of the table and the registers
  logic              held       [TABLE_ENTRIES];
  logic [ADDR_W-1:0] peer       [TABLE_ENTRIES];
  logic [FAIL_W-1:0] fails      [TABLE_ENTRIES];
  logic [TIME_W-1:0] first_seen [TABLE_ENTRIES];
  logic [TIME_W-1:0] now_tick;
  logic [FAIL_W-1:0] fail_limit;
  logic [TIME_W-1:0] ban_ticks;

  verdict_t due_verdicts[$];
  verdict_t due;
  verdict_t fresh;
  int       errors;

  assign mismatches = errors;
  assign awaiting   = due_verdicts.size();

  function automatic verdict_t apply_request(req_type_t kind, logic [ADDR_W-1:0] ip);
    verdict_t          v;
    int                hit;
    int                n;
    logic [TIME_W-1:0] age;
    v   = '0;
    hit = -1;
    if (kind == REQ_TICK) begin
      now_tick = now_tick + 1'b1;
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        age = now_tick - first_seen[i];
        if (held[i] && age >= ban_ticks) held[i] = 1'b0;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (hit < 0 && held[i] && peer[i] == ip) hit = i;
      case (kind)
        REQ_CHECK: begin
          if (hit >= 0)
            if (fails[hit] >= fail_limit) v.banned = 1'b1;
        end
        REQ_SUCCESS: begin
          if (hit >= 0) held[hit] = 1'b0;
        end
        default: begin
          if (hit >= 0) begin
            if (fails[hit] != FAIL_SAT) fails[hit] = fails[hit] + 1'b1;
          end else begin
            // new peer goes to the lowest free slot
            v.full = 1'b1;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
              if (v.full && !held[i]) begin
                held[i]       = 1'b1;
                peer[i]       = ip;
                fails[i]      = '0;
                first_seen[i] = now_tick;
                v.full        = 1'b0;
              end
            end
          end
        end
      endcase
    end
    n = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (held[i]) n++;
    v.in_use = n[ENTRY_W-1:0];
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) held[i] = 1'b0;
      now_tick   = '0;
      fail_limit = FAIL_RST;
      ban_ticks  = BAN_RST;
      due_verdicts.delete();
    end else begin
      // result first: a beat at this edge belongs to an older request
      if (out_tvalid && out_tready) begin
        if (due_verdicts.size() == 0) begin
          $error("result beat 0x%02h with no request outstanding", out_tdata);
          errors++;
        end else begin
          due = due_verdicts.pop_front();
          if (out_tdata[0] !== due.banned) begin
            $error("banned: expected %0b, got %0b", due.banned, out_tdata[0]);
            errors++;
          end
          if (out_tdata[1] !== due.full) begin
            $error("table_full: expected %0b, got %0b", due.full, out_tdata[1]);
            errors++;
          end
          if (out_tdata[6:2] !== due.in_use) begin
            $error("entries_in_use: expected %0d, got %0d", due.in_use, out_tdata[6:2]);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_MAX_FAIL)      fail_limit = cfg_wdata[FAIL_W-1:0];
        else if (cfg_index == REG_BAN_TIME) ban_ticks  = cfg_wdata[TIME_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        fresh = apply_request(req_type_t'(in_tuser), in_tdata);
        due_verdicts.insert(due_verdicts.size(), fresh);
      end
    end
  end

endmodule

@@ bench/failed_auth_ban_table_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// failed_auth_ban_table_top_tb
// Drives check, success, failure and tick requests into the ban table under
// several limit and ban-time settings, with random gaps on the request side
// and random stalls on the result side; the checker grades every result.
// ----------------------------------------------------------------------------
module failed_auth_ban_table_top_tb;
  import fabt_pkg::*;

  localparam int IDLE_LIMIT = 3000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata   = '0;   // [31:0] ip_address
  logic [1:0]           in_tuser   = '0;   // [1:0] req_type
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;         // [0] banned, [1] table_full,
                                           // [6:2] entries_in_use
  int mismatches;
  int awaiting;
  int in_gap_pct  = 0;
  int stall_pct   = 0;
  int hold_left   = 0;
  int idle_cycles = 0;
  logic [31:0] peers[40];

  always #1 clk = ~clk;

  failed_auth_ban_table_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ban_table_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  // mostly short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(2, 0);
    if (roll < 95) return $urandom_range(10, 3);
    return $urandom_range(80, 20);
  endfunction

  // result-side backpressure
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= 1'b1;
      if (stall_pct != 0 && $urandom_range(99) < stall_pct) hold_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // valid stays high into the next beat when no gap is drawn
  task automatic send_req(input req_type_t kind, input logic [31:0] ip);
    int gap;
    gap = (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  <= kind;
    in_tdata  <= ip;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // limit goes in with junk in the unused upper bits
  task automatic set_policy(input logic [7:0] limit, input logic [31:0] ban);
    write_reg(REG_MAX_FAIL, ($urandom() & 32'hFFFF_FF00) | limit);
    write_reg(REG_BAN_TIME, ban);
  endtask

  task automatic run_phase(input logic [7:0] limit, input logic [31:0] ban, input int n_req,
                           input int pool_n, input int tick_pct, input int gap_pct,
                           input int stall);
    int          roll;
    req_type_t   kind;
    logic [31:0] ip;
    drain();
    set_policy(limit, ban);
    in_gap_pct = gap_pct;
    stall_pct  = stall;
    for (int i = 0; i < pool_n; i++) begin
      roll     = $urandom_range(9);
      peers[i] = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFF_FFFF : $urandom();
    end
    for (int k = 0; k < n_req; k++) begin
      roll = $urandom_range(99);
      if (roll < tick_pct) begin
        kind = REQ_TICK;
      end else begin
        roll = $urandom_range(99);
        kind = (roll < 35) ? REQ_CHECK : (roll < 50) ? REQ_SUCCESS : REQ_FAIL;
      end
      ip = ($urandom_range(99) < 85) ? peers[$urandom_range(pool_n - 1)] : $urandom();
      send_req(kind, ip);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset policy: empty check, fill, overflow, ban, removal
    in_gap_pct = 20;
    stall_pct  = 20;
    send_req(REQ_CHECK, 32'h0);
    send_req(REQ_FAIL, 32'h0);
    send_req(REQ_FAIL, 32'hFFFF_FFFF);
    for (int i = 0; i < 14; i++) send_req(REQ_FAIL, 32'hC0A8_0000 + i);
    send_req(REQ_FAIL, 32'h0A00_0001);            // no room left
    repeat (5) send_req(REQ_FAIL, 32'hFFFF_FFFF); // reaches the limit exactly
    send_req(REQ_CHECK, 32'hFFFF_FFFF);
    send_req(REQ_CHECK, 32'h0);
    send_req(REQ_SUCCESS, 32'h0);
    send_req(REQ_SUCCESS, 32'h1234_5678);         // not in the table
    send_req(REQ_FAIL, 32'h5555_AAAA);            // refills the freed low slot
    // zero limit bans anything present; then everything ages out
    drain();
    set_policy(8'd0, 32'd2);
    send_req(REQ_TICK, 32'hFFFF_FFFF);
    send_req(REQ_CHECK, 32'hC0A8_0003);
    send_req(REQ_CHECK, 32'h0BAD_0BAD);
    send_req(REQ_TICK, 32'h0);
    send_req(REQ_CHECK, 32'hC0A8_0003);

    run_phase(8'd2,   32'd30,         250, 20, 20, 30, 30);
    run_phase(8'd255, 32'hFFFF_FFFF,  300,  3,  5, 10,  0); // limit at the saturation value
    run_phase(8'd0,   32'd1,          150, 10, 30,  0, 50);
    run_phase(8'd1,   32'd0,          100, 10, 10, 50, 20);
    run_phase(8'($urandom_range(8, 1)), 32'($urandom_range(60, 5)), 300, 24, 25, 20, 20);
    run_phase(8'd5,   32'd12,         200, 40, 15,  0,  0);

    drain();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
